FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// Sphere collision push-out package
// Request and response payload types, shared by the block and its checker,
// and the stored sphere entry and the action codes used by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned RAD_W   = 31;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [RAD_W-1:0]          sphere_radius;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] push_x;
    logic signed [COORD_W-1:0] push_y;
    logic signed [COORD_W-1:0] push_z;
    logic                      status;
  } rsp_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [RAD_W-1:0]          r;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/scp_cell.sv
// ----------------------------------------------------------------------------
// Sphere storage cell
// Holds one obstacle sphere; loads a new sphere or takes its neighbour's
// sphere when the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_cell (
  input  wire logic            clk_i,
  input  wire logic            load_i,
  input  wire scp_pkg::entry_t load_data_i,
  input  wire logic            shift_i,
  input  wire scp_pkg::entry_t shift_data_i,
  output scp_pkg::entry_t      data_o
);
  import scp_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= shift_data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/scp_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] val_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] val_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        run_q;
  logic        done_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_q <= {root_q[30:0], take};
      cnt_q  <= cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/scp_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_div #(
  parameter int unsigned NUM_W = 65,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;

  logic [DEN_W:0] rem_sh;
  logic           take;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign take   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
    end else if (run_q) begin
      rem_q <= take ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], take};
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

FILE: rtl/sphere_collision_pushout.sv
// An add, clear or unused request goes to the finish state, which answers once no earlier
// response is waiting. A check rotates the ring through every cell, squares and compares
// each stored sphere, and for each overlapping one takes a square root, then per axis a
// division, a scaling and an accumulation (only the root where centres nearly coincide).
// One request is in flight at a time. Reset (asynchronous, active low) empties the table
// and clears the control state; the sphere cells themselves are not cleared.
// ----------------------------------------------------------------------------
// Sphere collision push-out
// Keeps a ring of obstacle spheres and pushes a player sphere out of them.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_collision_pushout #(
  parameter int unsigned MAX_SPHERES = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire scp_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_ready_i,
  output scp_pkg::rsp_t      rsp_o
);
  import scp_pkg::*;

  // The count must be able to hold MAX_SPHERES itself.
  localparam int unsigned CNT_W = $clog2(MAX_SPHERES + 1);
  localparam int unsigned IDX_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  // Each push term is below 2^33, one term per sphere per axis.
  localparam int unsigned ACC_W = 35 + IDX_W;
  // The near-coincidence threshold of 0.001, rounded to the fixed-point grid.
  localparam int unsigned EPS   = ((1 << FRAC_BITS) + 500) / 1000;
  // Reciprocal of five: (y * RECIP5) >> 34 is exactly y / 5 for any 32-bit y.
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SQ, ST_CMP, ST_ROOT, ST_PROD,
    ST_QGO, ST_QWAIT, ST_SCALE, ST_ACC, ST_FINISH
  } state_e;

  state_e state_q;

  // Player sphere of the request in flight.
  logic signed [COORD_W-1:0] pl_x_q, pl_y_q, pl_z_q;
  logic [RAD_W-1:0]          pl_r_q;
  logic [1:0]                act_q;
  logic                      status_q;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] rot_q;

  // Per-sphere working registers; index 0, 1, 2 are the x, y and z axes.
  logic [31:0]      mag_q [3];
  logic             neg_q [3];
  logic [31:0]      rsum_q;
  logic [63:0]      sq_q  [3];
  logic [63:0]      rsq_q;
  logic [31:0]      dist_q;
  logic [31:0]      pen_q;
  logic [63:0]      prod_q;
  logic [31:0]      quot_q;
  logic [31:0]      half_q;
  logic [63:0]      scaled_q;
  logic [1:0]       ax_q;
  logic             hit_q;
  logic signed [ACC_W-1:0] acc_q [3];

  logic  rsp_valid_q;
  rsp_t  rsp_q;

  // The ring of sphere cells. Cell 0 is the head that feeds the datapath;
  // rotating moves every sphere one cell towards the head.
  entry_t cell_data [MAX_SPHERES];
  entry_t new_entry;
  logic   accept;
  logic   rotate;

  assign accept    = req_valid_i && req_ready_o;
  assign new_entry = '{x: req_i.pos_x, y: req_i.pos_y, z: req_i.pos_z,
                       r: req_i.sphere_radius};
  assign rotate    = (state_q == ST_SCAN) && (rot_q != CNT_W'(MAX_SPHERES));

  for (genvar k = 0; k < MAX_SPHERES; k++) begin : g_cell
    localparam int unsigned NXT = (k + 1) % MAX_SPHERES;
    logic load;
    assign load = accept && (req_i.action == ACT_ADD) && (count_q == CNT_W'(k));
    scp_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (load),
      .load_data_i  (new_entry),
      .shift_i      (rotate),
      .shift_data_i (cell_data[NXT]),
      .data_o       (cell_data[k])
    );
  end

  // Differences against the head sphere, one bit wider than the coordinates.
  entry_t            head;
  logic signed [32:0] dx, dy, dz;

  assign head = cell_data[0];
  assign dx   = {pl_x_q[31], pl_x_q} - {head.x[31], head.x};
  assign dy   = {pl_y_q[31], pl_y_q} - {head.y[31], head.y};
  assign dz   = {pl_z_q[31], pl_z_q} - {head.z[31], head.z};

  // Overlap test: the squared distance against the squared radius sum.
  logic [65:0] dist_sq;
  logic        overlap;

  assign dist_sq = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
  assign overlap = dist_sq < {2'b00, rsq_q};

  logic        sqrt_start;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  assign sqrt_start = (state_q == ST_CMP) && overlap;

  scp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (dist_sq[63:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // The divider gives the rounded quotient |d| * pen / dist. The quotient never
  // exceeds the penetration, so it fits in 32 bits.
  logic        div_start;
  logic        div_done;
  logic [64:0] div_num;
  logic [31:0] div_den;
  logic [64:0] div_quot;
  logic [31:0] quot;

  assign quot      = div_quot[31:0];
  assign div_start = (state_q == ST_QGO);
  assign div_num   = {1'b0, prod_q} + 65'(dist_q >> 1);
  assign div_den   = dist_q;

  scp_div #(.NUM_W(65), .DEN_W(32)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Scaling by 1.1 with rounding: (11q + 5) / 10 = q + ((q + 5) / 2) / 5.
  logic [32:0] push_mag;

  assign push_mag = {1'b0, quot_q} + {3'b000, scaled_q[63:34]};

  // Signed push term of the current axis and the saturated results.
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] sat_v [3];

  assign term = neg_q[ax_q] ? -ACC_W'(push_mag) : ACC_W'(push_mag);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (acc_q[a] > SAT_MAX) begin
        sat_v[a] = SAT_MAX;
      end else if (acc_q[a] < SAT_MIN) begin
        sat_v[a] = SAT_MIN;
      end else begin
        sat_v[a] = acc_q[a];
      end
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      act_q       <= ACT_ADD;
      status_q    <= 1'b0;
      hit_q       <= 1'b0;
      ax_q        <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      pl_x_q      <= '0;
      pl_y_q      <= '0;
      pl_z_q      <= '0;
      pl_r_q      <= '0;
      rsum_q      <= '0;
      rsq_q       <= '0;
      dist_q      <= '0;
      pen_q       <= '0;
      prod_q      <= '0;
      quot_q      <= '0;
      half_q      <= '0;
      scaled_q    <= '0;
      for (int a = 0; a < 3; a++) begin
        mag_q[a] <= '0;
        neg_q[a] <= 1'b0;
        sq_q[a]  <= '0;
        acc_q[a] <= '0;
      end
    end else begin
      // A taken response is dropped unless a new one replaces it this cycle.
      if (rsp_valid_q && rsp_ready_i && (state_q != ST_FINISH)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pl_x_q   <= req_i.pos_x;
            pl_y_q   <= req_i.pos_y;
            pl_z_q   <= req_i.pos_z;
            pl_r_q   <= req_i.sphere_radius;
            act_q    <= req_i.action;
            status_q <= 1'b0;
            hit_q    <= 1'b0;
            rot_q    <= '0;
            for (int a = 0; a < 3; a++) begin
              acc_q[a] <= '0;
            end
            state_q  <= ST_FINISH;
            case (req_i.action)
              ACT_ADD: begin
                if (count_q == CNT_W'(MAX_SPHERES)) begin
                  status_q <= 1'b1;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              ACT_CLEAR: begin
                count_q <= '0;
              end
              ACT_CHECK: begin
                state_q <= ST_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rot_q == CNT_W'(MAX_SPHERES)) begin
            state_q <= ST_FINISH;
          end else begin
            rot_q <= rot_q + CNT_W'(1);
            if (rot_q < count_q) begin
              mag_q[0] <= dx[32] ? 32'(-dx) : dx[31:0];
              mag_q[1] <= dy[32] ? 32'(-dy) : dy[31:0];
              mag_q[2] <= dz[32] ? 32'(-dz) : dz[31:0];
              neg_q[0] <= dx[32];
              neg_q[1] <= dy[32];
              neg_q[2] <= dz[32];
              rsum_q   <= {1'b0, pl_r_q} + {1'b0, head.r};
              state_q  <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          for (int a = 0; a < 3; a++) begin
            sq_q[a] <= mag_q[a] * mag_q[a];
          end
          rsq_q   <= rsum_q * rsum_q;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (overlap) begin
            hit_q   <= 1'b1;
            state_q <= ST_ROOT;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            dist_q <= sqrt_root;
            pen_q  <= rsum_q - sqrt_root;
            ax_q   <= '0;
            if (sqrt_root <= 32'(EPS)) begin
              // Centres nearly coincide: push straight up by the radius sum.
              acc_q[1] <= acc_q[1] + ACC_W'(rsum_q);
              state_q  <= ST_SCAN;
            end else begin
              state_q <= ST_PROD;
            end
          end
        end
        ST_PROD: begin
          prod_q  <= mag_q[ax_q] * pen_q;
          state_q <= ST_QGO;
        end
        ST_QGO: begin
          state_q <= ST_QWAIT;
        end
        ST_QWAIT: begin
          if (div_done) begin
            quot_q  <= quot;
            half_q  <= 32'((33'(quot) + 33'd5) >> 1);
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          scaled_q <= half_q * RECIP5;
          state_q  <= ST_ACC;
        end
        ST_ACC: begin
          acc_q[ax_q] <= acc_q[ax_q] + term;
          if (ax_q == 2'd2) begin
            state_q <= ST_SCAN;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= ST_PROD;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid_q || rsp_ready_i) begin
            rsp_valid_q   <= 1'b1;
            rsp_q.hit     <= hit_q;
            rsp_q.push_x  <= sat_v[0][31:0];
            rsp_q.push_y  <= sat_v[1][31:0];
            rsp_q.push_z  <= sat_v[2][31:0];
            rsp_q.status  <= (act_q == ACT_ADD) && status_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// Sphere collision push-out checker
// Port-level properties of the block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_ready_o,
  input wire scp_pkg::req_t req_i,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_ready_i,
  input wire scp_pkg::rsp_t rsp_o
);

  // A response stays offered until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("response withdrawn before it was taken");

  // Only one request is in flight.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted while another was in flight");

  // A refused add carries no hit and no push.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status |-> !rsp_o.hit && rsp_o.push_x == 0 &&
    rsp_o.push_y == 0 && rsp_o.push_z == 0)
    else $error("refused add reported a push");

  // Without a hit the push is zero.
  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.hit |-> rsp_o.push_x == 0 && rsp_o.push_y == 0 &&
    rsp_o.push_z == 0)
    else $error("push reported without a hit");

endmodule

bind sphere_collision_pushout scp_checker u_scp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

`default_nettype wire
